FILE: rtl/uer_pkg.sv
package uer_pkg;

  localparam int COUNTER_BITS_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_MM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Q4     = 3'd4;

  localparam logic [15:0] TRIGGER_TICKS_RST = 16'd4000;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd5000;
  localparam logic [15:0] SCALE_Q16_RST     = 16'd55706;
  localparam logic [7:0]  SPACING_MM_RST    = 8'd26;
  localparam logic [9:0]  OFFSET_Q4_RST     = 10'd192;

  localparam int DIST_W = 17;
  localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;

  // squared range is 48 bits, root is 24 bits
  localparam int RAD_W = 48;
  localparam int ROOT_W = 24;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_t;

  typedef struct packed {
    logic accept;
    logic tick;
    logic mul1;
    logic mul2;
    logic mul3;
    logic root_init;
    logic root_step;
    logic finish;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_range;
    logic root_last;
  } dp_status_t;

endpackage

FILE: rtl/ultrasonic_echo_ranger.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | in_start_req, in_echo_level
// out     | output    | out_valid/out_stall | trigger, busy, done, timed_out, pulse, distance
// cfg     | input     | cfg_valid/cfg_ready | cfg_index (3b), cfg_data (16b)
//
// One result per tick item. A plain tick stalls the input after it is accepted through
// the state update and the output load. The tick that ends a pulse stalls it through the
// state update, three multiply stages, subtract, 24 square-root iterations,
// rounding/offset and output load; no new item is taken before its result is loaded.
// The next item is taken while a result waits in the output register; a second finished
// result stalls the input until the first is taken. Synchronous active-low reset
// restores register defaults and the idle phase.
module ultrasonic_echo_ranger #(
  parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_start_req,
  input  logic                           in_echo_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_trigger_level,
  output logic                           out_busy_res,
  output logic                           out_done_res,
  output logic                           out_timed_out,
  output logic [15:0]                    out_pulse_ticks,
  output logic [uer_pkg::DIST_W-1:0]     out_distance_q4,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);

  uer_pkg::ctl_cmd_t   cmd;
  uer_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  uer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  uer_datapath #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_start_req      (in_start_req),
    .in_echo_level     (in_echo_level),
    .cmd               (cmd),
    .status            (status),
    .out_trigger_level (out_trigger_level),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_timed_out     (out_timed_out),
    .out_pulse_ticks   (out_pulse_ticks),
    .out_distance_q4   (out_distance_q4)
  );

endmodule

FILE: rtl/uer_ctrl.sv
module uer_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output uer_pkg::ctl_cmd_t    cmd,
  input  uer_pkg::dp_status_t  status
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_TICK = 8'b0000_0010,
    S_MUL1 = 8'b0000_0100,
    S_MUL2 = 8'b0000_1000,
    S_MUL3 = 8'b0001_0000,
    S_SUB  = 8'b0010_0000,
    S_ROOT = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       pend_r, pend_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || pend_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !pend_r) begin
          cmd.accept = 1'b1;
          state_nxt  = S_TICK;
        end
      end
      S_TICK: begin
        cmd.tick = 1'b1;
        if (status.need_range) begin
          state_nxt = S_MUL1;
        end else begin
          pend_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.root_init = 1'b1;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        pend_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // a finished item moves to the output register once it is free
    if (pend_r && out_free) begin
      cmd.load_out = 1'b1;
      pend_nxt     = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

endmodule

FILE: rtl/uer_datapath.sv
module uer_datapath #(
  parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_start_req,
  input  logic                               in_echo_level,
  input  uer_pkg::ctl_cmd_t                  cmd,
  output uer_pkg::dp_status_t                status,
  output logic                               out_trigger_level,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic                               out_timed_out,
  output logic [15:0]                        out_pulse_ticks,
  output logic [uer_pkg::DIST_W-1:0]         out_distance_q4
);

  localparam int CB = COUNTER_BITS;
  localparam int CW = (CB > 16) ? CB : 16;
  localparam logic [CB-1:0] CNT_MAX = '1;
  localparam int RW = uer_pkg::RAD_W;
  localparam int QW = uer_pkg::ROOT_W;
  localparam int DW = uer_pkg::DIST_W;

  // configuration
  logic [15:0] trig_ticks_r, tmo_ticks_r, scale_r;
  logic [7:0]  spacing_r;
  logic [9:0]  offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ticks_r <= uer_pkg::TRIGGER_TICKS_RST;
      tmo_ticks_r  <= uer_pkg::TIMEOUT_TICKS_RST;
      scale_r      <= uer_pkg::SCALE_Q16_RST;
      spacing_r    <= uer_pkg::SPACING_MM_RST;
      offset_r     <= uer_pkg::OFFSET_Q4_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uer_pkg::CFG_TRIGGER_TICKS: trig_ticks_r <= cfg_data;
        uer_pkg::CFG_TIMEOUT_TICKS: tmo_ticks_r  <= cfg_data;
        uer_pkg::CFG_SCALE_Q16:     scale_r      <= cfg_data;
        uer_pkg::CFG_SPACING_MM:    spacing_r    <= cfg_data[7:0];
        uer_pkg::CFG_OFFSET_Q4:     offset_r     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // latched input item
  logic start_r, echo_r;
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      start_r <= in_start_req;
      echo_r  <= in_echo_level;
    end
  end

  // tick state
  uer_pkg::phase_t phase_r, phase_nxt;
  logic [CB-1:0]   cnt_r, cnt_nxt;
  logic            tmo_flag_r, tmo_flag_nxt;
  logic [15:0]     pulse_r, pulse_nxt;
  logic [DW-1:0]   dist_r;
  logic            trig_r, trig_nxt;
  logic            done_r, done_nxt;
  logic            clr_dist;
  logic [CB-1:0]   cnt_up;
  logic [CW-1:0]   cnt_w;
  logic [15:0]     cnt_sat16;
  logic            tmo;

  function automatic logic hit_timeout(input logic [CB-1:0] c, input logic [15:0] lim);
    hit_timeout = (CW'(c) >= CW'(lim)) || (c == CNT_MAX);
  endfunction

  assign cnt_up    = (cnt_r == CNT_MAX) ? CNT_MAX : cnt_r + 1'b1;
  assign cnt_w     = CW'(cnt_r);
  assign cnt_sat16 = (cnt_w > CW'(16'hFFFF)) ? 16'hFFFF : cnt_w[15:0];

  assign status.need_range = (phase_r == uer_pkg::PH_MEAS) && !echo_r;

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    tmo_flag_nxt = tmo_flag_r;
    pulse_nxt    = pulse_r;
    trig_nxt     = 1'b0;
    done_nxt     = 1'b0;
    clr_dist     = 1'b0;
    tmo          = 1'b0;
    unique case (phase_r)
      uer_pkg::PH_IDLE: begin
        if (start_r) begin
          phase_nxt    = uer_pkg::PH_TRIG;
          cnt_nxt      = CB'(1);
          tmo_flag_nxt = 1'b0;
          trig_nxt     = 1'b1;
        end
      end
      uer_pkg::PH_TRIG: begin
        if ((CW'(cnt_r) >= CW'(trig_ticks_r)) || (cnt_r == CNT_MAX)) begin
          phase_nxt = uer_pkg::PH_WAIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt  = cnt_up;
          trig_nxt = 1'b1;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (echo_r) begin
          cnt_nxt   = CB'(1);
          phase_nxt = uer_pkg::PH_MEAS;
        end else begin
          cnt_nxt = cnt_up;
        end
        tmo = hit_timeout(cnt_nxt, tmo_ticks_r);
      end
      uer_pkg::PH_MEAS: begin
        if (echo_r) begin
          cnt_nxt = cnt_up;
          tmo     = hit_timeout(cnt_nxt, tmo_ticks_r);
        end else begin
          // range itself is filled in by the square-root sequence
          pulse_nxt    = cnt_sat16;
          tmo_flag_nxt = 1'b0;
          phase_nxt    = uer_pkg::PH_IDLE;
          done_nxt     = 1'b1;
        end
      end
      default: begin
        phase_nxt = uer_pkg::PH_IDLE;
      end
    endcase
    if (tmo) begin
      tmo_flag_nxt = 1'b1;
      pulse_nxt    = '0;
      clr_dist     = 1'b1;
      phase_nxt    = uer_pkg::PH_IDLE;
      done_nxt     = 1'b1;
    end
  end

  // range arithmetic
  logic [31:0]   prod_r;
  logic [32:0]   prod_rnd;
  logic [QW-1:0] d8_r;
  logic [29:0]   half_r;
  logic [RW-1:0] sq_r;
  logic [RW-1:0] rem_r, root_r, bit_r;
  logic [RW:0]   trial;
  logic [QW:0]   root_rnd;
  logic [21:0]   res;
  logic [15:0]   sp_sq;

  assign prod_rnd = {1'b0, prod_r} + 33'd128;
  assign sp_sq    = spacing_r * spacing_r;
  assign trial    = {1'b0, root_r} + {1'b0, bit_r};
  assign root_rnd = {1'b0, root_r[QW-1:0]} + (QW+1)'(8);
  assign res      = 22'(root_rnd[QW:4]) + 22'(offset_r);
  assign status.root_last = bit_r[0];

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod_r <= pulse_r * scale_r;
    end
    if (cmd.mul2) begin
      d8_r   <= prod_rnd[QW+7:8];
      half_r <= {sp_sq, 14'd0};
    end
    if (cmd.mul3) begin
      sq_r <= d8_r * d8_r;
    end
    if (cmd.root_init) begin
      rem_r  <= (sq_r > RW'(half_r)) ? sq_r - RW'(half_r) : '0;
      root_r <= '0;
      bit_r  <= RW'(1) << (RW - 2);
    end else if (cmd.root_step) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_r  <= rem_r - trial[RW-1:0];
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= uer_pkg::PH_IDLE;
      cnt_r      <= '0;
      tmo_flag_r <= 1'b0;
      pulse_r    <= '0;
      dist_r     <= '0;
      trig_r     <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      if (cmd.tick) begin
        phase_r    <= phase_nxt;
        cnt_r      <= cnt_nxt;
        tmo_flag_r <= tmo_flag_nxt;
        pulse_r    <= pulse_nxt;
        trig_r     <= trig_nxt;
        done_r     <= done_nxt;
        if (clr_dist) begin
          dist_r <= '0;
        end
      end
      if (cmd.finish) begin
        dist_r <= (res > 22'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX : res[DW-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_trigger_level <= trig_r;
      out_busy_res      <= (phase_r != uer_pkg::PH_IDLE);
      out_done_res      <= done_r;
      out_timed_out     <= tmo_flag_r;
      out_pulse_ticks   <= pulse_r;
      out_distance_q4   <= dist_r;
    end
  end

endmodule

FILE: test/ultrasonic_echo_ranger_check.sv
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_check #(
  parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_start_req,
  input  logic                           in_echo_level,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_trigger_level,
  input  logic                           out_busy_res,
  input  logic                           out_done_res,
  input  logic                           out_timed_out,
  input  logic [15:0]                    out_pulse_ticks,
  input  logic [uer_pkg::DIST_W-1:0]     out_distance_q4,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             outstanding,
  output logic                           ranging
);

  localparam longint unsigned CNT_TOP = (64'd1 << COUNTER_BITS) - 64'd1;

  typedef struct packed {
    logic                       trig;
    logic                       busy;
    logic                       done;
    logic                       tmo;
    logic [15:0]                pulse;
    logic [uer_pkg::DIST_W-1:0] distance;
  } tick_result_t;

  // register copies
  logic [15:0] trig_len;
  logic [15:0] tmo_len;
  logic [15:0] scale;
  logic [7:0]  spacing;
  logic [9:0]  offset;

  // ranging state
  uer_pkg::phase_t            ph;
  longint unsigned            cnt;
  logic                       tflag;
  logic [15:0]                lpulse;
  logic [uer_pkg::DIST_W-1:0] ldist;

  tick_result_t tick_results[$];
  tick_result_t seen;

  assign seen = {out_trigger_level, out_busy_res, out_done_res, out_timed_out,
                 out_pulse_ticks, out_distance_q4};

  initial begin
    fail_count = 0;
    outstanding = 0;
    ranging = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // d in Q8 mm, radicand in Q16 mm^2, root rounded half up to Q4
  function automatic logic [uer_pkg::DIST_W-1:0] range_q4(input longint unsigned ticks);
    longint unsigned t, d8, sq, half, rad, r4, res;
    t = (ticks > 64'd65535) ? 64'd65535 : ticks;
    d8 = (t * 64'(scale) + 64'd128) >> 8;
    sq = d8 * d8;
    half = (64'(spacing) * 64'(spacing)) << 14;
    rad = (sq > half) ? sq - half : 64'd0;
    r4 = (floor_sqrt(rad) + 64'd8) >> 4;
    res = r4 + 64'(offset);
    return (res > 64'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX : res[uer_pkg::DIST_W-1:0];
  endfunction

  function automatic longint unsigned count_next(input longint unsigned c);
    return (c >= CNT_TOP) ? CNT_TOP : c + 64'd1;
  endfunction

  function automatic logic timed_out_at(input longint unsigned c);
    return (c >= 64'(tmo_len)) || (c >= CNT_TOP);
  endfunction

  function automatic tick_result_t advance_tick(input logic start, input logic echo);
    tick_result_t r;
    logic expire;
    r = '0;
    expire = 1'b0;
    case (ph)
      uer_pkg::PH_IDLE: begin
        if (start) begin
          ph = uer_pkg::PH_TRIG;
          cnt = 1;
          tflag = 1'b0;
          r.trig = 1'b1;
        end
      end
      uer_pkg::PH_TRIG: begin
        if (cnt >= 64'(trig_len) || cnt >= CNT_TOP) begin
          ph = uer_pkg::PH_WAIT;
          cnt = 0;
        end else begin
          cnt = count_next(cnt);
          r.trig = 1'b1;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (echo) begin
          cnt = 1;
          ph = uer_pkg::PH_MEAS;
        end else begin
          cnt = count_next(cnt);
        end
        expire = timed_out_at(cnt);
      end
      uer_pkg::PH_MEAS: begin
        if (echo) begin
          cnt = count_next(cnt);
          expire = timed_out_at(cnt);
        end else begin
          lpulse = (cnt > 64'd65535) ? 16'hFFFF : cnt[15:0];
          ldist = range_q4(cnt);
          tflag = 1'b0;
          ph = uer_pkg::PH_IDLE;
          r.done = 1'b1;
        end
      end
      default: ph = uer_pkg::PH_IDLE;
    endcase
    if (expire) begin
      tflag = 1'b1;
      lpulse = '0;
      ldist = '0;
      ph = uer_pkg::PH_IDLE;
      r.done = 1'b1;
    end
    r.busy = (ph != uer_pkg::PH_IDLE);
    r.tmo = tflag;
    r.pulse = lpulse;
    r.distance = ldist;
    return r;
  endfunction

  task automatic check_result(input tick_result_t got);
    tick_result_t want;
    if (tick_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result item with nothing pending: trig=%0d busy=%0d done=%0d tmo=%0d %s%0d %s%0d",
                 got.trig, got.busy, got.done, got.tmo, "pulse=", got.pulse,
                 "distance=", got.distance);
    end else begin
      want = tick_results.pop_front();
      if (want !== got) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: want trig=%0d busy=%0d done=%0d tmo=%0d pulse=%0d distance=%0d %s",
                   want.trig, want.busy, want.done, want.tmo, want.pulse, want.distance,
                   "|");
        if (fail_count <= 10)
          $display("          got  trig=%0d busy=%0d done=%0d tmo=%0d pulse=%0d distance=%0d",
                   got.trig, got.busy, got.done, got.tmo, got.pulse, got.distance);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      trig_len = uer_pkg::TRIGGER_TICKS_RST;
      tmo_len = uer_pkg::TIMEOUT_TICKS_RST;
      scale = uer_pkg::SCALE_Q16_RST;
      spacing = uer_pkg::SPACING_MM_RST;
      offset = uer_pkg::OFFSET_Q4_RST;
      ph = uer_pkg::PH_IDLE;
      cnt = 0;
      tflag = 1'b0;
      lpulse = '0;
      ldist = '0;
      tick_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result(seen);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          uer_pkg::CFG_TRIGGER_TICKS: trig_len = cfg_data;
          uer_pkg::CFG_TIMEOUT_TICKS: tmo_len = cfg_data;
          uer_pkg::CFG_SCALE_Q16:     scale = cfg_data;
          uer_pkg::CFG_SPACING_MM:    spacing = cfg_data[7:0];
          uer_pkg::CFG_OFFSET_Q4:     offset = cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        tick_results.push_back(advance_tick(in_start_req, in_echo_level));
    end
    outstanding = tick_results.size();
    ranging = (ph != uer_pkg::PH_IDLE);
  end

endmodule

FILE: test/ultrasonic_echo_ranger_test.sv
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_test;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int DRAIN_TAIL    = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_ITEMS   = 100;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_start_req = 1'b0;
  logic                           in_echo_level = 1'b0;
  logic                           out_stall = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic                       in_stall;
  logic                       out_valid;
  logic                       out_trigger_level;
  logic                       out_busy_res;
  logic                       out_done_res;
  logic                       out_timed_out;
  logic [15:0]                out_pulse_ticks;
  logic [uer_pkg::DIST_W-1:0] out_distance_q4;
  logic                       cfg_ready;

  int   fail_count;
  int   outstanding;
  logic ranging;

  // stimulus bookkeeping
  logic        quiet = 1'b0;
  logic        pressure_req = 1'b0;
  int          sent_items = 0;
  int          burst_left = 0;
  logic [15:0] cur_trig = uer_pkg::TRIGGER_TICKS_RST;
  logic [15:0] cur_tmo = uer_pkg::TIMEOUT_TICKS_RST;

  // receiver pattern
  int          hold_left = 0;
  int          pat_left = 0;
  int          stall_pct = 0;
  logic        pressure_seen = 1'b0;
  int unsigned cycles = 0;

  ultrasonic_echo_ranger dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_req      (in_start_req),
    .in_echo_level     (in_echo_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trigger_level (out_trigger_level),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_timed_out     (out_timed_out),
    .out_pulse_ticks   (out_pulse_ticks),
    .out_distance_q4   (out_distance_q4),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  ultrasonic_echo_ranger_check echo_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_req      (in_start_req),
    .in_echo_level     (in_echo_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trigger_level (out_trigger_level),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_timed_out     (out_timed_out),
    .out_pulse_ticks   (out_pulse_ticks),
    .out_distance_q4   (out_distance_q4),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .outstanding       (outstanding),
    .ranging           (ranging)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL ultrasonic_echo_ranger");
      $finish;
    end
  end

  // receiver: one long hold-off on request, no stalls while quiet, otherwise random stall density per stretch
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (pressure_req && !pressure_seen) begin
      pressure_seen = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        case ($urandom_range(0, 4))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
        pat_left = $urandom_range(16, 96);
      end else begin
        pat_left--;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // one tick item; returns at a falling edge, valid possibly still high
  task automatic send_tick(input logic start, input logic echo);
    in_valid <= 1'b1;
    in_start_req <= start;
    in_echo_level <= echo;
    do @(posedge clk); while (in_stall);
    sent_items++;
    @(negedge clk);
    if (!quiet) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic cfg_write(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                           input logic [uer_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] trig, input logic [15:0] tmo,
                                input logic [15:0] scale, input logic [15:0] spacing,
                                input logic [15:0] offset);
    int unsigned pick;
    logic [uer_pkg::CFG_IDX_W-1:0] idx_v;
    cur_trig = trig;
    cur_tmo = tmo;
    // unmapped index, must be ignored
    if ($urandom_range(0, 1)) begin
      pick = $urandom_range(uer_pkg::CFG_OFFSET_Q4 + 1, (1 << uer_pkg::CFG_IDX_W) - 1);
      idx_v = pick[uer_pkg::CFG_IDX_W-1:0];
      cfg_write(idx_v, 16'($urandom_range(0, 65535)));
    end
    cfg_write(uer_pkg::CFG_TRIGGER_TICKS, trig);
    cfg_write(uer_pkg::CFG_TIMEOUT_TICKS, tmo);
    cfg_write(uer_pkg::CFG_SCALE_Q16, scale);
    cfg_write(uer_pkg::CFG_SPACING_MM, spacing);
    cfg_write(uer_pkg::CFG_OFFSET_Q4, offset);
    cfg_valid <= 1'b0;
  endtask

  // run out any measurement with quiet echo, then wait for every result
  task automatic settle();
    while (ranging) send_tick(1'b0, 1'b0);
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // well-formed measurement: start, trigger, echo low wait, echo high pulse, fall
  task automatic measure(input int wait_n, input int pulse_n);
    while (ranging) send_tick(1'b0, 1'b0);
    repeat ($urandom_range(0, 2)) send_tick(1'b0, 1'($urandom_range(0, 1)));
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat ((cur_trig == 0) ? 1 : cur_trig)
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    repeat (wait_n) send_tick(1'($urandom_range(0, 1)), 1'b0);
    repeat (pulse_n) send_tick(1'($urandom_range(0, 1)), 1'b1);
    send_tick(1'($urandom_range(0, 1)), 1'b0);
  endtask

  initial begin
    int target;
    int r;
    int wait_n;
    int pulse_n;
    logic [15:0] trig_v;
    logic [15:0] tmo_v;
    logic [15:0] scale_v;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register defaults
    quiet <= 1'b1;
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    settle();
    // short trigger so a full measurement fits; the other registers keep defaults
    cfg_write(uer_pkg::CFG_TRIGGER_TICKS, 16'd3);
    cfg_valid <= 1'b0;
    cur_trig = 16'd3;
    measure(3, 120);
    settle();
    quiet <= 1'b0;

    // widest spacing against a one-tick pulse: radicand goes negative
    apply_settings(16'd1, 16'd40, 16'hFFFF, 16'h00FF, 16'h03FF);
    measure(0, 1);
    measure(45, 5);
    measure(2, 50);
    settle();

    // zero trigger length and zero timeout
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    measure(0, 1);
    settle();

    apply_settings(16'd2, 16'd8, 16'd0, 16'd0, 16'd0);
    measure(1, 3);
    settle();

    for (int phase_i = 0; phase_i < RANDOM_PHASES; phase_i++) begin
      r = $urandom_range(0, 99);
      trig_v = (r < 10) ? 16'd0 : (r < 20) ? 16'd20 : 16'($urandom_range(1, 6));
      r = $urandom_range(0, 99);
      tmo_v = (r < 6) ? 16'd0 : (r < 12) ? 16'd1 : 16'($urandom_range(4, 90));
      r = $urandom_range(0, 99);
      scale_v = (r < 15) ? 16'd0 : (r < 30) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      apply_settings(trig_v, tmo_v, scale_v, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)));
      if (phase_i == 2) pressure_req <= 1'b1;
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          repeat ($urandom_range(1, 6))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (r < 20) begin
          // broken sequence: start, then echo wherever it falls
          send_tick(1'b1, 1'($urandom_range(0, 1)));
          repeat ($urandom_range(0, cur_trig + 4))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          wait_n = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, cur_tmo + 3);
          pulse_n = ($urandom_range(0, 99) < 75)
                    ? $urandom_range(1, (cur_tmo > 2) ? cur_tmo - 1 : 1)
                    : $urandom_range(1, cur_tmo + 4);
          measure(wait_n, pulse_n);
        end
      end
      settle();
    end

    repeat (DRAIN_TAIL) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS ultrasonic_echo_ranger");
    else
      $display("FAIL ultrasonic_echo_ranger");
    $finish;
  end

endmodule

FILE: ultrasonic_echo_ranger.f
rtl/uer_pkg.sv
rtl/uer_ctrl.sv
rtl/uer_datapath.sv
rtl/ultrasonic_echo_ranger.sv
test/ultrasonic_echo_ranger_check.sv
test/ultrasonic_echo_ranger_test.sv
